// ===== src/uart_frame_receiver_macros.svh =====
// assertion macros for the uart frame receiver checker
// no dependencies; included by the checker file only
`ifndef UART_FRAME_RECEIVER_MACROS_SVH
`define UART_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, off during reset
`define UFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define UFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset is seen
`define UFR_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ufr_pkg.sv =====
// shared types and constants of the uart frame receiver
// no dependencies; used by the interface users, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

  // configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HALF_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd5;

  localparam logic [23:0] RST_BIT_PERIOD     = 24'd2222;
  localparam logic [3:0]  RST_DATA_BITS      = 4'd8;
  localparam logic [1:0]  RST_PARITY_MODE    = 2'd0;
  localparam logic [2:0]  RST_STOP_HALF_BITS = 3'd2;
  localparam logic        RST_MSB_FIRST      = 1'b0;
  localparam logic [1:0]  RST_CHANNEL_ENABLE = 2'd3;

  localparam logic [1:0] PAR_ODD  = 2'd1;
  localparam logic [1:0] PAR_EVEN = 2'd2;

  // event codes
  localparam logic [3:0] EV_START_OK   = 4'd0;
  localparam logic [3:0] EV_START_ERR  = 4'd1;
  localparam logic [3:0] EV_DATA_BIT   = 4'd2;
  localparam logic [3:0] EV_DATA_WORD  = 4'd3;
  localparam logic [3:0] EV_PARITY_OK  = 4'd4;
  localparam logic [3:0] EV_PARITY_ERR = 4'd5;
  localparam logic [3:0] EV_STOP_OK    = 4'd6;
  localparam logic [3:0] EV_STOP_ERR   = 4'd7;
  localparam logic [3:0] EV_FRAME_ERR  = 4'd8;

  // frame phase codes
  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_PARITY = 3'd3;
  localparam logic [2:0] PH_STOP   = 3'd4;

  typedef struct packed {
    logic channel;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic       out_channel;
    logic [3:0] event_kind;
    logic [8:0] event_value;
    logic [3:0] bit_position;
    logic       last_of_item;
  } out_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       prev_level;
    logic [8:0] data_word;
    logic [3:0] data_count;
    logic [1:0] stop_count;
    logic       frame_ok;
  } line_state_t;

  localparam line_state_t LINE_RESET = '{
    phase:      PH_WAIT,
    prev_level: 1'b1,
    data_word:  9'd0,
    data_count: 4'd0,
    stop_count: 2'd0,
    frame_ok:   1'b1
  };

endpackage

`default_nettype wire

// ===== src/ufr_stream_if.sv =====
// valid/ready stream channel with a typed payload
// no dependencies; the payload type comes from ufr_pkg at instantiation
`timescale 1ns / 1ps
`default_nettype none

interface ufr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/uart_frame_receiver.sv =====
// top level of the uart frame receiver: per-line frame decoder and result queue
// depends on ufr_pkg and ufr_stream_if
//
//  channel | dir | handshake            | beat carries
//  --------+-----+----------------------+--------------------------------------------
//  in_ch   | in  | valid/ready          | channel, line_level (one line sample)
//  out_ch  | out | valid/ready          | out_channel, event_kind, event_value,
//          |     |                      | bit_position, last_of_item
//  cfg_*   | in  | cfg_we, no wait      | cfg_index selects register, cfg_wdata value
//
// one sample a cycle unless held: a beat goes to the input register, then the
// decoder works it out and drops its zero to two events into a four-entry queue
// results pass from the input register through the queue before they are visible
// the decoder holds its sample only while the queue has fewer than two free slots
// sync active-low reset: lines back to waiting, idle level high, queue empty
`timescale 1ns / 1ps
`default_nettype none

module uart_frame_receiver #(
  parameter int LINES                = 2,
  parameter int COUNT_WIDTH          = 24,
  parameter int PERIOD_FRACTION_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ufr_stream_if.sink                           in_ch,
  ufr_stream_if.source                         out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [ufr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ufr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ufr_pkg::*;

  // n*P is at most 5 x 24 bits; times four plus rounding still fits 33 bits
  localparam int PROD_W     = 29;
  localparam int NUM_W      = 33;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int FCNT_W     = 3;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [23:0] cfg_period_r;
  logic [3:0]  cfg_dbits_r;
  logic [1:0]  cfg_parity_r;
  logic [2:0]  cfg_stop_r;
  logic        cfg_msb_r;
  logic [1:0]  cfg_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_period_r <= RST_BIT_PERIOD;
      cfg_dbits_r  <= RST_DATA_BITS;
      cfg_parity_r <= RST_PARITY_MODE;
      cfg_stop_r   <= RST_STOP_HALF_BITS;
      cfg_msb_r    <= RST_MSB_FIRST;
      cfg_en_r     <= RST_CHANNEL_ENABLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_PERIOD:     cfg_period_r <= cfg_wdata[23:0];
        REG_DATA_BITS:      cfg_dbits_r  <= cfg_wdata[3:0];
        REG_PARITY_MODE:    cfg_parity_r <= cfg_wdata[1:0];
        REG_STOP_HALF_BITS: cfg_stop_r   <= cfg_wdata[2:0];
        REG_MSB_FIRST:      cfg_msb_r    <= cfg_wdata[0];
        REG_CHANNEL_ENABLE: cfg_en_r     <= cfg_wdata[1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // effective settings: word length clamped to 5..9, stop half bits 0 read as 2 and above 4 as 4
  logic [3:0] db;
  logic [2:0] h;
  logic       par_on;

  always_comb begin
    if (cfg_dbits_r < 4'd5) begin
      db = 4'd5;
    end else if (cfg_dbits_r > 4'd9) begin
      db = 4'd9;
    end else begin
      db = cfg_dbits_r;
    end
    if (cfg_stop_r == 3'd0) begin
      h = 3'd2;
    end else if (cfg_stop_r > 3'd4) begin
      h = 3'd4;
    end else begin
      h = cfg_stop_r;
    end
    par_on = (cfg_parity_r == PAR_ODD) || (cfg_parity_r == PAR_EVEN);
  end

  // input register
  logic     stage_v_r;
  in_item_t stage_r;
  logic     advance;
  logic     in_take;

  // result queue
  out_item_t           fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [FCNT_W-1:0]   fcnt_r;
  logic [1:0]          push_n;
  logic                pop;

  assign advance      = stage_v_r && (fcnt_r <= FCNT_W'(FIFO_DEPTH - 2));
  assign in_ch.ready  = !stage_v_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_take) begin
      stage_v_r <= 1'b1;
    end else if (advance) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_r <= in_ch.payload;
    end
  end

  // per-line state
  line_state_t            st_r  [LINES];
  logic [COUNT_WIDTH-1:0] cnt_r [LINES];

  line_state_t            cur;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic                   line_on;
  logic                   lvl;

  always_comb begin
    cur     = LINE_RESET;
    cur_cnt = '0;
    for (int l = 0; l < LINES; l++) begin
      if (stage_r.channel == 1'(l)) begin
        cur     = st_r[l];
        cur_cnt = cnt_r[l];
      end
    end
  end

  // samples of a line that is absent or switched off leave no trace
  assign line_on = (int'(stage_r.channel) < LINES) && cfg_en_r[stage_r.channel];
  assign lvl     = stage_r.line_level;

  // sample point of the bit in hand
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   half;
  logic [4:0]             n_sel;
  logic [PROD_W-1:0]      prod;
  logic [NUM_W-1:0]       num_mid;
  logic [NUM_W-1:0]       num_qtr;
  logic [NUM_W-1:0]       pt;
  logic                   hit;

  assign cnt_inc = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
  // exactly one half bit of stop time left
  assign half    = (h == {cur.stop_count, 1'b1});

  always_comb begin
    unique case (cur.phase)
      PH_DATA:   n_sel = 5'(cur.data_count) + 5'd1;
      PH_PARITY: n_sel = 5'(db) + 5'd1;
      PH_STOP:   n_sel = 5'(db) + 5'(par_on) + 5'(cur.stop_count) + 5'd1;
      default:   n_sel = 5'd0;
    endcase
  end

  assign prod    = PROD_W'(n_sel) * PROD_W'(cfg_period_r);
  // round half up: mid at n*P + P/2, quarter at n*P + P/4
  assign num_mid = (NUM_W'(prod) << 1) + NUM_W'(cfg_period_r)
                 + (NUM_W'(1) << PERIOD_FRACTION_BITS);
  assign num_qtr = (NUM_W'(prod) << 2) + NUM_W'(cfg_period_r)
                 + (NUM_W'(1) << (PERIOD_FRACTION_BITS + 1));
  assign pt      = ((cur.phase == PH_STOP) && half) ? (num_qtr >> (PERIOD_FRACTION_BITS + 2))
                                                    : (num_mid >> (PERIOD_FRACTION_BITS + 1));
  // a point past the counter limit is clamped, so a saturated count always hits
  assign hit     = (NUM_W'(cnt_inc) >= pt) || (cnt_inc == COUNT_MAX);

  // data bit placement and parity
  logic [3:0] idx;
  logic [4:0] idx_p1;
  logic [3:0] pos;
  logic [8:0] word_new;
  logic [8:0] mask;
  logic       par_x;
  logic       par_good;
  logic [1:0] sc_n;
  logic       stop_end;

  assign idx      = cur.data_count;
  assign idx_p1   = 5'(idx) + 5'd1;
  assign pos      = cfg_msb_r ? (db - 4'd1 - idx) : idx;
  assign word_new = cur.data_word | (9'(lvl) << pos);
  assign sc_n     = cur.stop_count + 2'd1;
  assign stop_end = ({sc_n, 1'b0} >= h);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mask[i] = (4'(i) < db);
    end
  end

  assign par_x = ^(cur.data_word & mask) ^ lvl;

  always_comb begin
    unique case (cfg_parity_r)
      PAR_ODD:  par_good = par_x;
      PAR_EVEN: par_good = !par_x;
      default:  par_good = 1'b1;
    endcase
  end

  function automatic out_item_t mk_ev(input logic ch, input logic [3:0] kind,
                                      input logic [8:0] val, input logic [3:0] bpos);
    out_item_t e;
    e.out_channel  = ch;
    e.event_kind   = kind;
    e.event_value  = val;
    e.bit_position = bpos;
    e.last_of_item = 1'b0;
    return e;
  endfunction

  // frame decoder
  line_state_t            st_nxt;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  out_item_t              ev0;
  out_item_t              ev1;
  logic [1:0]             n_ev;

  always_comb begin
    st_nxt  = cur;
    cnt_nxt = cur_cnt;
    ev0     = mk_ev(stage_r.channel, EV_START_OK, 9'd0, 4'd0);
    ev1     = ev0;
    n_ev    = 2'd0;

    if ((cur.phase == PH_WAIT) || (cur.phase > PH_STOP)) begin
      st_nxt.phase = PH_WAIT;
      // falling edge opens a frame; this sample is sample zero
      if (cur.prev_level && !lvl) begin
        st_nxt       = LINE_RESET;
        st_nxt.phase = PH_START;
        cnt_nxt      = '0;
      end
    end else begin
      cnt_nxt = cnt_inc;
      unique case (cur.phase)
        PH_START: begin
          if (hit) begin
            if (lvl) begin
              st_nxt.frame_ok = 1'b0;
              ev0             = mk_ev(stage_r.channel, EV_START_ERR, 9'd0, 4'd0);
              ev1             = mk_ev(stage_r.channel, EV_FRAME_ERR, 9'd0, 4'd0);
              n_ev            = 2'd2;
              st_nxt.phase    = PH_WAIT;
            end else begin
              ev0               = mk_ev(stage_r.channel, EV_START_OK, 9'd0, 4'd0);
              n_ev              = 2'd1;
              st_nxt.data_count = 4'd0;
              st_nxt.phase      = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (hit) begin
            ev0  = mk_ev(stage_r.channel, EV_DATA_BIT, 9'(lvl), idx);
            n_ev = 2'd1;
            // a bit past a shortened word is reported but not stored
            if (idx < db) begin
              st_nxt.data_word = word_new;
            end
            st_nxt.data_count = idx_p1[3:0];
            if (idx_p1 >= 5'(db)) begin
              ev1               = mk_ev(stage_r.channel, EV_DATA_WORD, st_nxt.data_word,
                                        4'd0);
              n_ev              = 2'd2;
              st_nxt.stop_count = 2'd0;
              st_nxt.phase      = par_on ? PH_PARITY : PH_STOP;
            end
          end
        end
        PH_PARITY: begin
          if (hit) begin
            if (par_good) begin
              ev0 = mk_ev(stage_r.channel, EV_PARITY_OK, 9'd0, 4'd0);
            end else begin
              ev0             = mk_ev(stage_r.channel, EV_PARITY_ERR, 9'd0, 4'd0);
              st_nxt.frame_ok = 1'b0;
            end
            n_ev              = 2'd1;
            st_nxt.stop_count = 2'd0;
            st_nxt.phase      = PH_STOP;
          end
        end
        default: begin  // stop bits
          if (hit) begin
            if (lvl) begin
              ev0 = mk_ev(stage_r.channel, EV_STOP_OK, 9'd0, 4'd0);
            end else begin
              ev0             = mk_ev(stage_r.channel, EV_STOP_ERR, 9'd0, 4'd0);
              st_nxt.frame_ok = 1'b0;
            end
            n_ev              = 2'd1;
            st_nxt.stop_count = sc_n;
            if (stop_end) begin
              if (!st_nxt.frame_ok) begin
                ev1  = mk_ev(stage_r.channel, EV_FRAME_ERR, 9'd0, 4'd0);
                n_ev = 2'd2;
              end
              st_nxt.phase = PH_WAIT;
            end
          end
        end
      endcase
    end

    st_nxt.prev_level = lvl;

    // mark the final event of this sample
    if (n_ev == 2'd1) begin
      ev0.last_of_item = 1'b1;
    end
    if (n_ev == 2'd2) begin
      ev1.last_of_item = 1'b1;
    end
  end

  for (genvar l = 0; l < LINES; l++) begin : g_line
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[l]  <= LINE_RESET;
        cnt_r[l] <= '0;
      end else if (advance && line_on && (stage_r.channel == 1'(l))) begin
        st_r[l]  <= st_nxt;
        cnt_r[l] <= cnt_nxt;
      end
    end
  end

  // result queue: up to two writes per cycle, one read
  assign push_n = (advance && line_on) ? n_ev : 2'd0;
  assign pop    = (fcnt_r != '0) && out_ch.ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= ev0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      fcnt_r   <= fcnt_r + FCNT_W'(push_n) - FCNT_W'(pop);
    end
  end

  assign out_ch.valid   = (fcnt_r != '0);
  assign out_ch.payload = fifo_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== src/ufr_checker.sv =====
// port-level checks of the uart frame receiver, bound to the top level
// depends on ufr_pkg and uart_frame_receiver_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "uart_frame_receiver_macros.svh"

module ufr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ufr_pkg::out_item_t out_item
);
  import ufr_pkg::*;

  // a result beat stays offered until taken
  `UFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out beat dropped")

  // only data events carry a value or a position
  `UFR_ASSERT_SAME(a_plain_zero, clk, rst_n, out_valid && (out_item.event_kind != EV_DATA_BIT) && (out_item.event_kind != EV_DATA_WORD), (out_item.event_value == 9'd0) && (out_item.bit_position == 4'd0), "non-data event with payload")

  // a data bit is one bit at a position inside the longest word
  `UFR_ASSERT_SAME(a_bit_range, clk, rst_n, out_valid && (out_item.event_kind == EV_DATA_BIT), (out_item.event_value <= 9'd1) && (out_item.bit_position <= 4'd8), "data bit out of range")

  // a bad start bit is followed at once by its frame error
  `UFR_ASSERT_NEXT(a_start_err, clk, rst_n, out_valid && out_ready && (out_item.event_kind == EV_START_ERR), out_valid && (out_item.event_kind == EV_FRAME_ERR), "start error without frame error")

  // reset empties the result queue
  `UFR_ASSERT_RESET(a_rst_empty, clk, rst_n, !out_valid, "result offered after reset")

endmodule

bind uart_frame_receiver ufr_checker u_ufr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);

`default_nettype wire

// ===== verif/ufr_event_checker.sv =====
// event checker for the uart frame receiver: predicts the events of every accepted sample beat
// and compares each result beat against the oldest prediction; depends on ufr_pkg
`timescale 1ns / 1ps

module ufr_event_checker
  import ufr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_beat,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_beat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_events
);

  localparam int FRAC = 8;
  localparam int CNT_W = 24;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;

  logic [23:0] reg_period;
  logic [3:0]  reg_bits;
  logic [1:0]  reg_parity;
  logic [2:0]  reg_stop;
  logic        reg_msb;
  logic [1:0]  reg_lines;

  line_state_t       lines      [0:1];
  logic [CNT_W-1:0]  line_count [0:1];

  out_item_t expected_events[$];
  int reports;

  // rounded sample point of bit n, mid-bit or quarter-bit, clamped to the counter range
  function automatic longint unsigned bit_sample_at(input int unsigned n, input bit quarter);
    longint unsigned p;
    longint unsigned num;
    p = reg_period;
    if (quarter) begin
      num = (4 * longint'(n) * p + p + (64'd1 << (FRAC + 1))) >> (FRAC + 2);
    end else begin
      num = (2 * longint'(n) * p + p + (64'd1 << FRAC)) >> (FRAC + 1);
    end
    return (num > CNT_MAX) ? CNT_MAX : num;
  endfunction

  function automatic bit parity_enabled();
    return reg_parity == PAR_ODD || reg_parity == PAR_EVEN;
  endfunction

  task automatic note_event(input logic ch, input logic [3:0] kind, input logic [8:0] value,
                            input logic [3:0] pos);
    out_item_t ev;
    ev.out_channel  = ch;
    ev.event_kind   = kind;
    ev.event_value  = value;
    ev.bit_position = pos;
    ev.last_of_item = 1'b0;
    expected_events.push_back(ev);
  endtask

  task automatic decode_sample(input logic ch, input logic lvl);
    int unsigned db;
    int unsigned idx;
    int unsigned nb;
    int unsigned pos;
    int h;
    int rem;
    int ones;
    int queued_at_entry;
    bit good;
    longint unsigned pt;
    out_item_t tail;
    if (!reg_lines[ch]) return;
    queued_at_entry = expected_events.size();
    db = (reg_bits < 5) ? 5 : (reg_bits > 9) ? 9 : reg_bits;

    if (lines[ch].phase == PH_WAIT || lines[ch].phase > PH_STOP) begin
      lines[ch].phase = PH_WAIT;
      if (lines[ch].prev_level && !lvl) begin
        line_count[ch]        = '0;
        lines[ch].data_word   = '0;
        lines[ch].data_count  = '0;
        lines[ch].stop_count  = '0;
        lines[ch].frame_ok    = 1'b1;
        lines[ch].phase       = PH_START;
      end
    end else begin
      if (line_count[ch] != '1) line_count[ch] = line_count[ch] + 1'b1;
      case (lines[ch].phase)
        PH_START: begin
          if (line_count[ch] >= bit_sample_at(0, 1'b0)) begin
            if (lvl) begin
              lines[ch].frame_ok = 1'b0;
              note_event(ch, EV_START_ERR, '0, '0);
              note_event(ch, EV_FRAME_ERR, '0, '0);
              lines[ch].phase = PH_WAIT;
            end else begin
              note_event(ch, EV_START_OK, '0, '0);
              lines[ch].data_count = '0;
              lines[ch].phase = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          idx = lines[ch].data_count;
          if (line_count[ch] >= bit_sample_at(idx + 1, 1'b0)) begin
            note_event(ch, EV_DATA_BIT, 9'(lvl), 4'(idx));
            // bits past the current word length are reported but dropped
            if (idx < db) begin
              pos = reg_msb ? (db - 1 - idx) : idx;
              lines[ch].data_word = lines[ch].data_word | (9'(lvl) << pos);
            end
            lines[ch].data_count = 4'(idx + 1);
            if (idx + 1 >= db) begin
              note_event(ch, EV_DATA_WORD, lines[ch].data_word, '0);
              lines[ch].stop_count = '0;
              lines[ch].phase = parity_enabled() ? PH_PARITY : PH_STOP;
            end
          end
        end
        PH_PARITY: begin
          if (line_count[ch] >= bit_sample_at(1 + db, 1'b0)) begin
            ones = lvl;
            for (int i = 0; i < db; i++) ones += lines[ch].data_word[i];
            if (reg_parity == PAR_ODD) good = (ones % 2) == 1;
            else if (reg_parity == PAR_EVEN) good = (ones % 2) == 0;
            else good = 1'b1;
            if (good) begin
              note_event(ch, EV_PARITY_OK, '0, '0);
            end else begin
              lines[ch].frame_ok = 1'b0;
              note_event(ch, EV_PARITY_ERR, '0, '0);
            end
            lines[ch].stop_count = '0;
            lines[ch].phase = PH_STOP;
          end
        end
        default: begin
          h = (reg_stop == 0) ? 2 : (reg_stop > 4) ? 4 : reg_stop;
          nb = 1 + db + (parity_enabled() ? 1 : 0) + lines[ch].stop_count;
          rem = h - 2 * int'(lines[ch].stop_count);
          pt = bit_sample_at(nb, rem == 1);
          if (line_count[ch] >= pt) begin
            if (!lvl) begin
              lines[ch].frame_ok = 1'b0;
              note_event(ch, EV_STOP_ERR, '0, '0);
            end else begin
              note_event(ch, EV_STOP_OK, '0, '0);
            end
            lines[ch].stop_count = lines[ch].stop_count + 1'b1;
            if (2 * int'(lines[ch].stop_count) >= h) begin
              if (!lines[ch].frame_ok) note_event(ch, EV_FRAME_ERR, '0, '0);
              lines[ch].phase = PH_WAIT;
            end
          end
        end
      endcase
    end

    lines[ch].prev_level = lvl;
    if (expected_events.size() > queued_at_entry) begin
      tail = expected_events.pop_back();
      tail.last_of_item = 1'b1;
      expected_events.push_back(tail);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      reg_period = RST_BIT_PERIOD;
      reg_bits   = RST_DATA_BITS;
      reg_parity = RST_PARITY_MODE;
      reg_stop   = RST_STOP_HALF_BITS;
      reg_msb    = RST_MSB_FIRST;
      reg_lines  = RST_CHANNEL_ENABLE;
      for (int i = 0; i < 2; i++) begin
        lines[i]      = LINE_RESET;
        line_count[i] = '0;
      end
      expected_events.delete();
      fail_count = 0;
      reports    = 0;
    end else begin
      // results first: a beat taken at this edge cannot show up at the same edge
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          if (reports < 10) begin
            reports++;
            $display("%0t unexpected result: ch %0d kind %0d value %0d pos %0d last %0d",
                     $realtime, out_beat.out_channel, out_beat.event_kind,
                     out_beat.event_value, out_beat.bit_position, out_beat.last_of_item);
          end
        end else begin
          want = expected_events.pop_front();
          if (want.out_channel !== out_beat.out_channel ||
              want.event_kind !== out_beat.event_kind ||
              want.event_value !== out_beat.event_value ||
              want.bit_position !== out_beat.bit_position ||
              want.last_of_item !== out_beat.last_of_item) begin
            fail_count++;
            if (reports < 10) begin
              reports++;
              $display("%0t mismatch: expected ch %0d kind %0d value %0d pos %0d last %0d, got ch %0d kind %0d value %0d pos %0d last %0d",
                       $realtime, want.out_channel, want.event_kind, want.event_value,
                       want.bit_position, want.last_of_item, out_beat.out_channel,
                       out_beat.event_kind, out_beat.event_value, out_beat.bit_position,
                       out_beat.last_of_item);
            end
          end
        end
      end
      if (in_valid && in_ready) decode_sample(in_beat.channel, in_beat.line_level);
      if (cfg_we) begin
        case (cfg_index)
          REG_BIT_PERIOD:     reg_period = cfg_wdata[23:0];
          REG_DATA_BITS:      reg_bits   = cfg_wdata[3:0];
          REG_PARITY_MODE:    reg_parity = cfg_wdata[1:0];
          REG_STOP_HALF_BITS: reg_stop   = cfg_wdata[2:0];
          REG_MSB_FIRST:      reg_msb    = cfg_wdata[0];
          REG_CHANNEL_ENABLE: reg_lines  = cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
    pending_events = expected_events.size();
  end

endmodule

// ===== verif/testbench.sv =====
// top of the uart frame receiver testbench: clock, reset, line-sample stimulus and verdict
// depends on ufr_pkg, ufr_stream_if, uart_frame_receiver and ufr_event_checker
`timescale 1ns / 1ps

module testbench;
  import ufr_pkg::*;

  // kinds of line activity queued for one line
  typedef enum int {
    SHAPE_FRAME,
    SHAPE_GLITCH,
    SHAPE_CUT,
    SHAPE_NOISE
  } burst_shape_t;

  // parity codes the package leaves unnamed
  localparam logic [1:0] PAR_NONE   = 2'd0;
  localparam logic [1:0] PAR_SPARE  = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ufr_stream_if #(.T(in_item_t))  in_if ();
  ufr_stream_if #(.T(out_item_t)) out_if ();

  int fail_count;
  int pending_events;

  // idling knobs, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;
  // long receiver hold-off, counted down in the receiver process
  bit hold_request = 1'b0;
  int hold_left    = 0;

  // copy of the register settings, used to shape the waveforms
  logic [23:0] s_period;
  logic [3:0]  s_bits;
  logic [1:0]  s_par;
  logic [2:0]  s_stop;
  logic [1:0]  s_en;

  // pending line levels, one queue per line
  bit wave0[$];
  bit wave1[$];

  uart_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ufr_event_checker event_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_beat        (in_if.payload),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_beat       (out_if.payload),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_events (pending_events)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic int wave_size(input bit ch);
    return ch ? wave1.size() : wave0.size();
  endfunction

  task automatic push_level(input bit ch, input bit lvl);
    if (ch) wave1.push_back(lvl);
    else wave0.push_back(lvl);
  endtask

  // queue idle time and then one burst of line activity, shaped by the current settings
  task automatic queue_burst(input bit ch, input burst_shape_t shape, input logic [8:0] word,
                             input bit bad_par, input bit bad_stop);
    bit levels [0:15];
    int db;
    int par_on;
    int h;
    int nsamp;
    int cut;
    int n;
    int glen;
    longint span;
    logic [8:0] data_mask;
    bit pbit;
    // idle high so the start bit is a real falling edge
    repeat ($urandom_range(3, 1)) push_level(ch, 1'b1);
    db = (s_bits < 5) ? 5 : (s_bits > 9) ? 9 : s_bits;
    par_on = (s_par == PAR_ODD || s_par == PAR_EVEN) ? 1 : 0;
    h = (s_stop == 0) ? 2 : (s_stop > 4) ? 4 : s_stop;
    case (shape)
      SHAPE_GLITCH: begin
        // low pulse shorter than half a bit, start check sees high
        glen = ((int'(s_period) + 256) >> 9) - 1;
        if (glen < 1) glen = 1;
        if (glen > 8) glen = 8;
        repeat ($urandom_range(glen, 1)) push_level(ch, 1'b0);
      end
      SHAPE_NOISE: begin
        repeat ($urandom_range(12, 4)) push_level(ch, 1'($urandom_range(1)));
      end
      default: begin
        foreach (levels[i]) levels[i] = 1'b1;
        levels[0] = 1'b0;
        for (int i = 0; i < db; i++) levels[1 + i] = word[i];
        data_mask = 9'((1 << db) - 1);
        pbit = ^(word & data_mask);
        if (s_par == PAR_ODD) pbit = ~pbit;
        pbit = pbit ^ bad_par;
        if (par_on != 0) levels[1 + db] = pbit;
        if (bad_stop) levels[1 + db + par_on] = 1'b0;
        // frame length in samples; very long periods only get a head of the frame
        span = longint'(1 + db + par_on) * s_period + (longint'(h) * s_period) / 2;
        for (nsamp = 0; longint'(nsamp) * 256 < span && nsamp < 400; nsamp++) ;
        cut = (shape == SHAPE_CUT) ? $urandom_range(nsamp - 1, 1) : nsamp;
        for (int k = 0; k < cut; k++) begin
          n = int'((longint'(k) * 256) / s_period);
          if (n > 15) n = 15;
          push_level(ch, levels[n]);
        end
      end
    endcase
  endtask

  // next level of a line, refilled with random activity when dry
  task automatic take_level(input bit ch, output bit lvl);
    int r;
    logic [8:0] word;
    if (wave_size(ch) == 0) begin
      r = $urandom_range(99);
      case ($urandom_range(3))
        0: word = '0;
        1: word = '1;
        default: word = 9'($urandom);
      endcase
      if (r < 80) queue_burst(ch, SHAPE_FRAME, word, $urandom_range(9) == 0,
                              $urandom_range(9) == 0);
      else if (r < 88) queue_burst(ch, SHAPE_GLITCH, word, 1'b0, 1'b0);
      else if (r < 94) queue_burst(ch, SHAPE_CUT, word, 1'b0, 1'b0);
      else queue_burst(ch, SHAPE_NOISE, word, 1'b0, 1'b0);
    end
    lvl = ch ? wave1.pop_front() : wave0.pop_front();
  endtask

  // one sample beat; entered and left at a falling edge
  task automatic send_beat(input bit ch, input bit lvl);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{channel: ch, line_level: lvl};
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // stop offering beats and wait for the block to drain
  task automatic settle_block(input int tail);
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending_events != 0);
    repeat (tail) @(negedge clk);
  endtask

  // one register write per falling edge; the caller lowers the enable
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [23:0] p, input logic [3:0] nbits,
                                input logic [1:0] par, input logic [2:0] stop,
                                input logic msb, input logic [1:0] en);
    s_period = p;
    s_bits   = nbits;
    s_par    = par;
    s_stop   = stop;
    s_en     = en;
    reg_write(REG_BIT_PERIOD, p);
    reg_write(REG_DATA_BITS, 24'(nbits));
    reg_write(REG_PARITY_MODE, 24'(par));
    reg_write(REG_STOP_HALF_BITS, 24'(stop));
    reg_write(REG_MSB_FIRST, 24'(msb));
    reg_write(REG_CHANNEL_ENABLE, 24'(en));
    cfg_we <= 1'b0;
  endtask

  // random sample beats; only beats on enabled lines count, unless all lines are off
  task automatic run_items(input int count, input int hold_at, input int pause_at);
    int sent;
    bit ch;
    bit lvl;
    sent = 0;
    while (sent < count) begin
      // rotate through the idling patterns every 40 beats
      case ((sent / 40) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      case (s_en)
        2'd1: ch = ($urandom_range(9) == 0);
        2'd2: ch = ($urandom_range(9) != 0);
        default: ch = 1'($urandom_range(1));
      endcase
      take_level(ch, lvl);
      // stray sample flips
      if ($urandom_range(49) == 0) lvl = ~lvl;
      send_beat(ch, lvl);
      if (s_en[ch] || s_en == 2'd0) begin
        sent++;
        // receiver holds off while beats keep coming, so the block backs up
        if (sent == hold_at) hold_request = 1'b1;
        // sender pauses until every predicted event is out
        if (sent == pause_at) settle_block(0);
      end
    end
  endtask

  initial begin
    bit lvl;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    s_period      = RST_BIT_PERIOD;
    s_bits        = RST_DATA_BITS;
    s_par         = RST_PARITY_MODE;
    s_stop        = RST_STOP_HALF_BITS;
    s_en          = RST_CHANNEL_ENABLE;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: shortest period, 5 bits, odd parity, half stop bit, line 1 off
    apply_settings(24'd512, 4'd5, PAR_ODD, 3'd1, 1'b0, 2'd1);
    // samples of a disabled line are dropped
    send_beat(1'b1, 1'b0);
    send_beat(1'b1, 1'b1);
    // falling edge then high at mid start bit: start error plus frame error
    send_beat(1'b0, 1'b0);
    send_beat(1'b0, 1'b1);
    send_beat(1'b0, 1'b1);
    // one clean frame of all ones
    queue_burst(1'b0, SHAPE_FRAME, 9'h1ff, 1'b0, 1'b0);
    while (wave_size(1'b0) != 0) begin
      lvl = wave0.pop_front();
      send_beat(1'b0, lvl);
    end

    // widest word, even parity, two stop bits, msb first
    settle_block(8);
    apply_settings(24'd512, 4'd9, PAR_EVEN, 3'd4, 1'b1, 2'd3);
    run_items(170, -1, -1);

    settle_block(8);
    apply_settings(24'($urandom_range(1200, 512)), 4'd8, PAR_NONE, 3'd2, 1'b0, 2'd3);
    run_items(170, 60, -1);

    // reset period, word length and stop length above range, spare parity code
    settle_block(8);
    apply_settings(RST_BIT_PERIOD, 4'd15, PAR_SPARE, 3'd7, 1'b1, 2'd1);
    run_items(170, -1, -1);

    // word length and stop length zero, only line 1
    settle_block(8);
    apply_settings(24'($urandom_range(1600, 512)), 4'd0, PAR_ODD, 3'd0, 1'b0, 2'd2);
    run_items(170, -1, 90);

    // longest period: frames start but nothing is sampled yet
    settle_block(8);
    apply_settings(24'hffffff, 4'd7, PAR_EVEN, 3'd3, 1'b1, 2'd3);
    run_items(40, -1, -1);

    // both lines off, frames left open from before
    settle_block(8);
    apply_settings(24'd700, 4'd6, PAR_NONE, 3'd1, 1'b0, 2'd0);
    run_items(20, -1, -1);

    repeat (3) begin
      settle_block(8);
      apply_settings(24'($urandom_range(1600, 512)), 4'($urandom_range(15)),
                     2'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                     2'($urandom_range(3, 1)));
      run_items(170, -1, -1);
    end

    settle_block(20);
    if (fail_count == 0 && pending_events == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ufr_pkg.sv
src/ufr_stream_if.sv
src/uart_frame_receiver.sv
src/ufr_checker.sv
verif/ufr_event_checker.sv
verif/testbench.sv
